>>> design/stfd_pkg.sv
// shared types and constants for the sync/type frame decoder
package stfd_pkg;

    localparam int unsigned NUM_SLOTS = 6;
    localparam int unsigned CODE_W    = 8;
    localparam int unsigned LEN_W     = 7;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 48;
    localparam int unsigned CODES_W   = NUM_SLOTS * CODE_W;
    localparam int unsigned LENS_W    = NUM_SLOTS * LEN_W;
    localparam int unsigned OUT_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_CODES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_LENGTHS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_LIMIT = 3'd4;

    localparam logic [7:0]         RST_SYNC_FIRST   = 8'hA5;
    localparam logic [7:0]         RST_SYNC_SECOND  = 8'h5A;
    localparam logic [CODES_W-1:0] RST_TYPE_CODES   = 48'h0605_0403_0201;
    localparam logic [LENS_W-1:0]  RST_TYPE_LENGTHS = '0;
    localparam logic [LEN_W-1:0]   RST_ACCEPT_LIMIT = 7'd32;

    typedef enum logic [2:0] {
        ST_SYNC_A,
        ST_SYNC_B,
        ST_TYPE,
        ST_DATA,
        ST_PRIME,
        ST_REPLAY
    } t_state;

    typedef struct packed {
        logic load_type;
        logic emit_empty;
        logic store_byte;
        logic prime;
        logic rep_load;
    } t_cmd;

    typedef struct packed {
        logic is_sync1;
        logic is_sync2;
        logic type_hit;
        logic len_zero;
        logic data_done;
        logic over_limit;
        logic rep_last;
        logic out_free;
    } t_stat;

endpackage

>>> design/stfd_ctrl.sv
// frame hunt and replay controller
module stfd_ctrl
    import stfd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   in_acc;

    assign in_acc = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SYNC_A;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_SYNC_A: begin
                if (in_acc && i_stat.is_sync1) begin
                    n_state = ST_SYNC_B;
                end
            end
            ST_SYNC_B: begin
                if (in_acc) begin
                    if (i_stat.is_sync2) begin
                        n_state = ST_TYPE;
                    end else if (!i_stat.is_sync1) begin
                        n_state = ST_SYNC_A;
                    end
                end
            end
            ST_TYPE: begin
                if (in_acc) begin
                    if (i_stat.type_hit) begin
                        n_state = i_stat.len_zero ? ST_SYNC_A : ST_DATA;
                    end else begin
                        n_state = i_stat.is_sync1 ? ST_SYNC_B : ST_SYNC_A;
                    end
                end
            end
            ST_DATA: begin
                if (in_acc && i_stat.data_done) begin
                    n_state = i_stat.over_limit ? ST_SYNC_A : ST_PRIME;
                end
            end
            ST_PRIME: begin
                n_state = ST_REPLAY;
            end
            ST_REPLAY: begin
                if (i_stat.out_free && i_stat.rep_last) begin
                    n_state = ST_SYNC_A;
                end
            end
            default: begin
                n_state = ST_SYNC_A;
            end
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        unique case (r_state)
            ST_SYNC_A, ST_SYNC_B, ST_DATA: begin
                o_in_ready = 1'b1;
            end
            ST_TYPE: begin
                o_in_ready = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        o_cmd.load_type  = (r_state == ST_TYPE) && in_acc && i_stat.type_hit
                           && !i_stat.len_zero;
        o_cmd.emit_empty = (r_state == ST_TYPE) && in_acc && i_stat.type_hit
                           && i_stat.len_zero;
        o_cmd.store_byte = (r_state == ST_DATA) && in_acc;
        o_cmd.prime      = (r_state == ST_PRIME);
        o_cmd.rep_load   = (r_state == ST_REPLAY) && i_stat.out_free;
    end

endmodule

>>> design/stfd_dpath.sv
// config registers, type lookup, payload memory and output register
module stfd_dpath
    import stfd_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic [7:0]           i_in_byte,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [7:0]           o_msg_type,
    output logic [LEN_W-1:0]     o_payload_length,
    output logic [IDX_W-1:0]     o_byte_index,
    output logic [7:0]           o_payload_byte,
    output logic                 o_last
);

    localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    logic [7:0]         r_sync1;
    logic [7:0]         r_sync2;
    logic [CODES_W-1:0] r_codes;
    logic [LENS_W-1:0]  r_lens;
    logic [LEN_W-1:0]   r_limit;

    logic [7:0]       r_held_type;
    logic [LEN_W-1:0] r_exp;
    logic [LEN_W-1:0] r_rcv;
    logic [IDX_W-1:0] r_idx;
    logic [7:0]       r_rd_data;
    logic [7:0]       mem [MAX_PAYLOAD];

    logic             r_out_valid;
    logic [7:0]       r_out_type;
    logic [LEN_W-1:0] r_out_len;
    logic [IDX_W-1:0] r_out_idx;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    logic             hit;
    logic [LEN_W-1:0] raw_len;
    logic [LEN_W-1:0] sat_len;
    logic [LEN_W-1:0] idx_next;
    logic [AW-1:0]    rd_addr;
    logic             out_free;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync1 <= RST_SYNC_FIRST;
            r_sync2 <= RST_SYNC_SECOND;
            r_codes <= RST_TYPE_CODES;
            r_lens  <= RST_TYPE_LENGTHS;
            r_limit <= RST_ACCEPT_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_FIRST:   r_sync1 <= i_cfg_data[7:0];
                CFG_SYNC_SECOND:  r_sync2 <= i_cfg_data[7:0];
                CFG_TYPE_CODES:   r_codes <= i_cfg_data[CODES_W-1:0];
                CFG_TYPE_LENGTHS: r_lens  <= i_cfg_data[LENS_W-1:0];
                CFG_ACCEPT_LIMIT: r_limit <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // lowest matching slot wins
    always_comb begin
        hit     = 1'b0;
        raw_len = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
            if (r_codes[CODE_W*s +: CODE_W] == i_in_byte) begin
                hit     = 1'b1;
                raw_len = r_lens[LEN_W*s +: LEN_W];
            end
        end
    end

    assign sat_len  = (raw_len > MAX_LEN) ? MAX_LEN : raw_len;
    assign idx_next = {1'b0, r_idx} + LEN_W'(1);
    assign rd_addr  = i_cmd.prime ? '0 : idx_next[AW-1:0];
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat            = '0;
        o_stat.is_sync1   = (i_in_byte == r_sync1);
        o_stat.is_sync2   = (i_in_byte == r_sync2);
        o_stat.type_hit   = hit;
        o_stat.len_zero   = (sat_len == '0);
        o_stat.data_done  = ((r_rcv + LEN_W'(1)) == r_exp);
        o_stat.over_limit = (r_exp > r_limit);
        o_stat.rep_last   = (idx_next == r_exp);
        o_stat.out_free   = out_free;
    end

    // frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_type <= '0;
            r_exp       <= '0;
            r_rcv       <= '0;
            r_idx       <= '0;
        end else begin
            if (i_cmd.load_type) begin
                r_held_type <= i_in_byte;
                r_exp       <= sat_len;
                r_rcv       <= '0;
            end else if (i_cmd.store_byte) begin
                r_rcv <= r_rcv + LEN_W'(1);
            end
            if (i_cmd.prime) begin
                r_idx <= '0;
            end else if (i_cmd.rep_load) begin
                r_idx <= idx_next[IDX_W-1:0];
            end
        end
    end

    // payload memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte) begin
            mem[r_rcv[AW-1:0]] <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prime || i_cmd.rep_load) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_empty || i_cmd.rep_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_empty) begin
            r_out_type <= i_in_byte;
            r_out_len  <= '0;
            r_out_idx  <= '0;
            r_out_byte <= '0;
            r_out_last <= 1'b1;
        end else if (i_cmd.rep_load) begin
            r_out_type <= r_held_type;
            r_out_len  <= r_exp;
            r_out_idx  <= r_idx;
            r_out_byte <= r_rd_data;
            r_out_last <= (idx_next == r_exp);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_msg_type       = r_out_type;
    assign o_payload_length = r_out_len;
    assign o_byte_index     = r_out_idx;
    assign o_payload_byte   = r_out_byte;
    assign o_last           = r_out_last;

endmodule

>>> design/sync_type_frame_decoder_core.sv
// top level of the two-byte sync / type / length frame decoder
// The decoder takes one received byte per word on the slave stream and
// hunts for the sync pair, looks the type byte up in six programmable slots
// and collects the payload into an internal memory of MAX_PAYLOAD bytes.
// While waiting for the sync pair and collecting payload it accepts one byte
// per cycle; the type byte of a frame is taken only when the output register
// is free or being drained. After the last payload byte of an accepted
// frame the input is held off during replay: the prime state loads the
// payload memory's registered read port, then one result word leaves per
// cycle, fewer when the master side stalls. Frames longer than accept_limit
// are dropped without replay. The user must write configuration via i_cfg_we /
// i_cfg_idx / i_cfg_data only while idle, which the block does not enforce.
module sync_type_frame_decoder_core
    import stfd_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // in_byte
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // msg_type, payload_length, byte_index, payload_byte, zero pad
    output logic [OUT_W-1:0]     m_axis_tdata,
    output logic                 m_axis_tlast   // last
);

    t_cmd             cmd;
    t_stat            stat;
    logic [7:0]       msg_type;
    logic [LEN_W-1:0] payload_length;
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       payload_byte;

    stfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    stfd_dpath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_byte        (s_axis_tdata),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_msg_type       (msg_type),
        .o_payload_length (payload_length),
        .o_byte_index     (byte_index),
        .o_payload_byte   (payload_byte),
        .o_last           (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, payload_byte, byte_index, payload_length, msg_type};

endmodule
